// ----- hdl/rrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and constants for the register rename table: instruction and
// result payloads, opcode and command-kind codes, and default sizes.
// ----------------------------------------------------------------------------
package rrt_pkg;

    // architectural register file shape
    localparam int ARCH_REGS        = 4;
    localparam int REG_IDX_W        = 2;
    localparam int OP_W             = 3;
    localparam int VALUE_W          = 64;
    localparam int OUT_TAG_W        = 10;

    // default physical store size and queue depth between the stages
    localparam int PHYS_ENTRIES_DEF = 1024;
    localparam int QUEUE_DEPTH      = 2;

    // instruction opcodes as they arrive on the input
    typedef enum logic [OP_W-1:0] {
        OP_MOV_REG = 3'd0,
        OP_MOV_IMM = 3'd1,
        OP_INC     = 3'd2,
        OP_DEC     = 3'd3,
        OP_SUB     = 3'd4
    } t_op;

    // classified command kinds handed from front to back
    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_MOVE,
        KIND_LOAD,
        KIND_INC,
        KIND_DEC,
        KIND_SUB
    } t_kind;

    // one decoded instruction
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [REG_IDX_W-1:0]     dest_reg;
        logic [REG_IDX_W-1:0]     src_reg;
        logic signed [VALUE_W-1:0] immediate;
    } t_item;

    // classified command in the queue between front and back
    typedef struct packed {
        t_kind                    kind;
        logic [REG_IDX_W-1:0]     dest_reg;
        logic [REG_IDX_W-1:0]     src_reg;
        logic [VALUE_W-1:0]       immediate;
    } t_cmd;

    // one result: full mapping snapshot after the instruction
    typedef struct packed {
        logic [OUT_TAG_W-1:0]      reg0_tag;
        logic [OUT_TAG_W-1:0]      reg1_tag;
        logic [OUT_TAG_W-1:0]      reg2_tag;
        logic [OUT_TAG_W-1:0]      reg3_tag;
        logic signed [VALUE_W-1:0] reg0_value;
        logic signed [VALUE_W-1:0] reg1_value;
        logic signed [VALUE_W-1:0] reg2_value;
        logic signed [VALUE_W-1:0] reg3_value;
        logic                      full_error;
    } t_result;

endpackage

// ----- hdl/rrt_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_fifo
// Small synchronous queue with registered storage, used between the front
// and back stages and as the result buffer.
// ----------------------------------------------------------------------------
module rrt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/rrt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_front
// Instruction intake: classifies each instruction into a command kind and
// pushes it into the command queue.
// ----------------------------------------------------------------------------
module rrt_front
    import rrt_pkg::*;
(
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_queue_full,
    output logic  o_full,
    output logic  o_cmd_push,
    output t_cmd  o_cmd
);

    t_kind kind;

    // opcode classification; unused codes become no-ops
    always_comb begin
        case (i_item.op)
            OP_MOV_REG: kind = KIND_MOVE;
            OP_MOV_IMM: kind = KIND_LOAD;
            OP_INC:     kind = KIND_INC;
            OP_DEC:     kind = KIND_DEC;
            OP_SUB:     kind = KIND_SUB;
            default:    kind = KIND_NOP;
        endcase
    end

    // command build and queue transfer
    assign o_full             = i_queue_full;
    assign o_cmd_push         = i_push && !i_queue_full;
    assign o_cmd.kind         = kind;
    assign o_cmd.dest_reg     = i_item.dest_reg;
    assign o_cmd.src_reg      = i_item.src_reg;
    assign o_cmd.immediate    = i_item.immediate;

endmodule

// ----- hdl/rrt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_back
// Alias table execution: holds the tag and value behind each architectural
// register, allocates physical entries and builds the result snapshot.
// ----------------------------------------------------------------------------
module rrt_back
    import rrt_pkg::*;
#(
    parameter int PHYS_ENTRIES = PHYS_ENTRIES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int TAG_W = $clog2(PHYS_ENTRIES);
    localparam int NF_W  = TAG_W + 1;

    // physical tag and the (immutable) entry value behind each register
    logic [TAG_W-1:0]   r_tag   [ARCH_REGS];
    logic [VALUE_W-1:0] r_value [ARCH_REGS];
    logic [NF_W-1:0]    r_next_free;

    logic [TAG_W-1:0]   n_tag   [ARCH_REGS];
    logic [VALUE_W-1:0] n_value [ARCH_REGS];
    logic [NF_W-1:0]    n_next_free;

    logic               fire;
    logic               exhausted;
    logic               alloc;
    logic [VALUE_W-1:0] dval;
    logic [VALUE_W-1:0] sval;
    logic [TAG_W-1:0]   stag;
    logic [VALUE_W-1:0] result;

    assign fire       = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = fire;
    assign o_res_push = fire;
    assign exhausted  = (r_next_free == NF_W'(PHYS_ENTRIES));
    assign alloc      = (i_cmd.kind == KIND_LOAD) || (i_cmd.kind == KIND_INC) ||
                        (i_cmd.kind == KIND_DEC)  || (i_cmd.kind == KIND_SUB);

    // operand select from the register lanes
    always_comb begin
        dval = '0;
        sval = '0;
        stag = '0;
        for (int i = 0; i < ARCH_REGS; i++) begin
            if (i_cmd.dest_reg == REG_IDX_W'(i)) begin
                dval = r_value[i];
            end
            if (i_cmd.src_reg == REG_IDX_W'(i)) begin
                sval = r_value[i];
                stag = r_tag[i];
            end
        end
    end

    // value for allocating ops, wraps at 64 bits
    always_comb begin
        case (i_cmd.kind)
            KIND_LOAD: result = i_cmd.immediate;
            KIND_INC:  result = dval + VALUE_W'(1);
            KIND_DEC:  result = dval - VALUE_W'(1);
            KIND_SUB:  result = dval - sval;
            default:   result = '0;
        endcase
    end

    // table update
    always_comb begin
        n_next_free = r_next_free;
        for (int i = 0; i < ARCH_REGS; i++) begin
            n_tag[i]   = r_tag[i];
            n_value[i] = r_value[i];
        end
        if (i_cmd.kind == KIND_MOVE) begin
            // move elimination: copy the source mapping
            for (int i = 0; i < ARCH_REGS; i++) begin
                if (i_cmd.dest_reg == REG_IDX_W'(i)) begin
                    n_tag[i]   = stag;
                    n_value[i] = sval;
                end
            end
        end else if (alloc && !exhausted) begin
            for (int i = 0; i < ARCH_REGS; i++) begin
                if (i_cmd.dest_reg == REG_IDX_W'(i)) begin
                    n_tag[i]   = r_next_free[TAG_W-1:0];
                    n_value[i] = result;
                end
            end
            n_next_free = r_next_free + 1'b1;
        end
    end

    // result snapshot after the update
    assign o_res.reg0_tag   = OUT_TAG_W'(n_tag[0]);
    assign o_res.reg1_tag   = OUT_TAG_W'(n_tag[1]);
    assign o_res.reg2_tag   = OUT_TAG_W'(n_tag[2]);
    assign o_res.reg3_tag   = OUT_TAG_W'(n_tag[3]);
    assign o_res.reg0_value = n_value[0];
    assign o_res.reg1_value = n_value[1];
    assign o_res.reg2_value = n_value[2];
    assign o_res.reg3_value = n_value[3];
    assign o_res.full_error = alloc && exhausted;

    // table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ARCH_REGS; i++) begin
                r_tag[i]   <= TAG_W'(i);
                r_value[i] <= '0;
            end
            r_next_free <= NF_W'(ARCH_REGS);
        end else if (fire) begin
            for (int i = 0; i < ARCH_REGS; i++) begin
                r_tag[i]   <= n_tag[i];
                r_value[i] <= n_value[i];
            end
            r_next_free <= n_next_free;
        end
    end

endmodule

// ----- hdl/register_rename_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_rename_table
// Register alias table for four architectural registers with move
// elimination and in-order allocation of physical entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is a queue write side: an instruction transfers on a clock
//   edge with push high and full low. Result channel is a queue read side:
//   the oldest result is shown while empty is low and transfers on an edge
//   with pop high.
//   Every instruction gives exactly one result: all four tags and values
//   after the instruction, plus full_error when an allocating instruction
//   found the physical store exhausted and was dropped.
//   Each transferring instruction is written into the command queue; the
//   table update then writes its result into the result queue, where it
//   is shown and can be popped.
//   Throughput: one instruction per cycle while the receiver keeps popping,
//   set by the table update in the back stage.
//   Reset (synchronous, active low) maps register i to entry i with value
//   zero, sets the next free entry to 4 and empties both queues; no
//   clearing pass is needed.
//   When the receiver stalls, the result queue fills, then the command
//   queue, and full rises after two further instructions.
// ----------------------------------------------------------------------------
module register_rename_table
    import rrt_pkg::*;
#(
    parameter int PHYS_ENTRIES = PHYS_ENTRIES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic    cmd_push;
    t_cmd    cmd_in;
    logic    cmd_full;
    t_cmd    cmd_out;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_push;
    t_result res_in;
    logic    res_full;

    // intake and classification
    rrt_front u_front (
        .i_push       (push),
        .i_item       (i_item),
        .i_queue_full (cmd_full),
        .o_full       (full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    // command queue between front and back
    rrt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // alias table execution
    rrt_back #(
        .PHYS_ENTRIES (PHYS_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue toward the receiver
    rrt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ----- hdl/rrt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_checker
// Port-level checks for the register rename table, bound to the top level.
// ----------------------------------------------------------------------------
module rrt_checker
    import rrt_pkg::*;
#(
    parameter int PHYS_ENTRIES = PHYS_ENTRIES_DEF
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input t_item   i_item,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    logic tags_in_range;

    // every shown tag names a real physical entry
    assign tags_in_range = (PHYS_ENTRIES > (1 << OUT_TAG_W)) ||
        ((32'(o_result.reg0_tag) < PHYS_ENTRIES) &&
         (32'(o_result.reg1_tag) < PHYS_ENTRIES) &&
         (32'(o_result.reg2_tag) < PHYS_ENTRIES) &&
         (32'(o_result.reg3_tag) < PHYS_ENTRIES));

    // reset leaves both queues empty
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // input backs up only behind a waiting result
    a_full_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input full while no result waits");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("stalled result changed");

    // shown tags stay inside the physical store
    a_tags_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> tags_in_range)
        else $error("result tag beyond physical store");

endmodule

bind register_rename_table rrt_checker #(
    .PHYS_ENTRIES (PHYS_ENTRIES)
) u_rrt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_item   (i_item),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// ----- tb/rename_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rename_checker
// Watches the instruction and result queues of the register rename table.
// Keeps a shadow alias map and value store, predicts the mapping snapshot
// after every accepted instruction and compares each popped result, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rename_checker
    import rrt_pkg::*;
#(
    parameter int PHYS_ENTRIES = PHYS_ENTRIES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_full,
    input  t_item   i_item,
    input  logic    i_empty,
    input  logic    i_pop,
    input  t_result i_result,
    output int      o_pending,
    output int      o_errors
);

    // shadow rename state
    int                 alias_tag [ARCH_REGS];
    logic [VALUE_W-1:0] phys_value [PHYS_ENTRIES];
    int                 next_free;

    // snapshots still owed by the block, oldest first
    t_result expected_snapshots [$];
    int      n_results;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        n_results = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t result %0d: %s", $time, n_results, msg);
        o_errors++;
    endtask

    task automatic check_field(input string field, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", field, got, want));
    endtask

    // rename one instruction and return the snapshot that follows it
    function automatic t_result apply_instruction(input t_item ins);
        logic [VALUE_W-1:0] dst_val;
        logic [VALUE_W-1:0] src_val;
        logic [VALUE_W-1:0] new_val;
        logic               needs_entry;
        logic               dropped;
        t_result            snap;
        dst_val     = phys_value[alias_tag[ins.dest_reg]];
        src_val     = phys_value[alias_tag[ins.src_reg]];
        new_val     = '0;
        needs_entry = 1'b1;
        dropped     = 1'b0;
        case (ins.op)
            OP_MOV_REG: begin
                // move elimination: share the source's entry
                alias_tag[ins.dest_reg] = alias_tag[ins.src_reg];
                needs_entry = 1'b0;
            end
            OP_MOV_IMM: new_val = ins.immediate;
            OP_INC:     new_val = dst_val + 1'b1;
            OP_DEC:     new_val = dst_val - 1'b1;
            OP_SUB:     new_val = dst_val - src_val;
            default:    needs_entry = 1'b0;
        endcase
        // allocate in order, drop when the store is used up
        if (needs_entry) begin
            if (next_free >= PHYS_ENTRIES) begin
                dropped = 1'b1;
            end else begin
                phys_value[next_free]   = new_val;
                alias_tag[ins.dest_reg] = next_free;
                next_free++;
            end
        end
        snap.reg0_tag   = OUT_TAG_W'(alias_tag[0]);
        snap.reg1_tag   = OUT_TAG_W'(alias_tag[1]);
        snap.reg2_tag   = OUT_TAG_W'(alias_tag[2]);
        snap.reg3_tag   = OUT_TAG_W'(alias_tag[3]);
        snap.reg0_value = phys_value[alias_tag[0]];
        snap.reg1_value = phys_value[alias_tag[1]];
        snap.reg2_value = phys_value[alias_tag[2]];
        snap.reg3_value = phys_value[alias_tag[3]];
        snap.full_error = dropped;
        return snap;
    endfunction

    // watch both queues
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < ARCH_REGS; r++) begin
                alias_tag[r]  = r;
                phys_value[r] = '0;
            end
            next_free = ARCH_REGS;
            expected_snapshots.delete();
        end else begin
            // result side first: no result belongs to an instruction of this edge
            if (i_pop && !i_empty) begin
                if (expected_snapshots.size() == 0) begin
                    report_mismatch("result with no instruction outstanding");
                end else begin
                    want = expected_snapshots.pop_front();
                    check_field("reg0_tag", i_result.reg0_tag, want.reg0_tag);
                    check_field("reg1_tag", i_result.reg1_tag, want.reg1_tag);
                    check_field("reg2_tag", i_result.reg2_tag, want.reg2_tag);
                    check_field("reg3_tag", i_result.reg3_tag, want.reg3_tag);
                    check_field("reg0_value", i_result.reg0_value, want.reg0_value);
                    check_field("reg1_value", i_result.reg1_value, want.reg1_value);
                    check_field("reg2_value", i_result.reg2_value, want.reg2_value);
                    check_field("reg3_value", i_result.reg3_value, want.reg3_value);
                    check_field("full_error", i_result.full_error, want.full_error);
                end
                n_results++;
            end
            if (i_push && !i_full)
                expected_snapshots.push_back(apply_instruction(i_item));
        end
        o_pending <= expected_snapshots.size();
    end

endmodule

// ----- tb/tb_register_rename_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_rename_table
// Drives decoded instructions into the register rename table with random
// gaps and stalls on both queues. A directed opening covers wraparound,
// move elimination and unused opcodes; random traffic then runs the physical
// store to exhaustion and beyond. Checking is done by rename_checker.
// ----------------------------------------------------------------------------
module tb_register_rename_table;
    import rrt_pkg::*;

    localparam int ITEMS          = 1050;
    localparam int ALLOC_SLOTS    = PHYS_ENTRIES_DEF - ARCH_REGS;
    localparam int TAIL_ALLOCS    = 20;
    localparam int PAUSE_AT       = 500;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // opcodes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    // architectural registers
    localparam logic [REG_IDX_W-1:0] REG_RAX = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RBX = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RCX = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RDX = 2'd3;

    localparam logic signed [VALUE_W-1:0] IMM_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] IMM_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] IMM_ONES = '1;
    localparam logic signed [VALUE_W-1:0] IMM_0101 = {(VALUE_W/2){2'b01}};
    localparam logic signed [VALUE_W-1:0] IMM_1010 = {(VALUE_W/2){2'b10}};

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    logic    full;
    t_item   item    = '0;
    logic    empty;
    logic    pop     = 1'b0;
    t_result result;

    int n_errors;
    int n_pending;
    int n_sent      = 0;
    int n_alloc     = 0;
    int send_calm   = 0;
    int pop_calm    = 0;
    int pop_wait    = 0;
    int idle_cycles = 0;

    register_rename_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (item),
        .empty   (empty),
        .pop     (pop),
        .o_result(result)
    );

    rename_checker #(
        .PHYS_ENTRIES(PHYS_ENTRIES_DEF)
    ) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_full   (full),
        .i_item   (item),
        .i_empty  (empty),
        .i_pop    (pop),
        .i_result (result),
        .o_pending(n_pending),
        .o_errors (n_errors)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // idle length: mostly short, a few long, with calm stretches of none
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // fields an op ignores get random content
    function automatic t_item make_item(input logic [OP_W-1:0] op,
                                        input logic [REG_IDX_W-1:0] dest,
                                        input logic [REG_IDX_W-1:0] src,
                                        input logic [VALUE_W-1:0] imm);
        t_item ins;
        ins.op        = op;
        ins.dest_reg  = dest;
        ins.src_reg   = (op == OP_MOV_REG || op == OP_SUB) ? src : REG_IDX_W'($urandom);
        ins.immediate = (op == OP_MOV_IMM) ? imm : {$urandom, $urandom};
        return ins;
    endfunction

    // random instruction, allocation heavy so the store runs out
    function automatic t_item random_item();
        t_item ins;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 4)
            ins.op = OP_MOV_REG;
        else if (r < 6)
            ins.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else
            ins.op = OP_W'($urandom_range(OP_MOV_IMM, OP_SUB));
        ins.dest_reg = REG_IDX_W'($urandom);
        ins.src_reg  = REG_IDX_W'($urandom);
        case ($urandom_range(0, 7))
            0:       ins.immediate = IMM_MAX;
            1:       ins.immediate = IMM_MIN;
            2:       ins.immediate = int'($urandom_range(0, 16)) - 8;
            default: ins.immediate = {$urandom, $urandom};
        endcase
        return ins;
    endfunction

    // one instruction transfer after a random gap
    task automatic send_item(input t_item ins);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        item <= ins;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_sent++;
        if (ins.op >= OP_MOV_IMM && ins.op <= OP_SUB) n_alloc++;
    endtask

    // hold the sender until every result is back
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    // result side: pop with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) pop_wait = pick_gap(pop_calm);
            if (pop_wait > 0) begin
                pop <= 1'b0;
                pop_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wraparound at zero and at the signed extremes
        send_item(make_item(OP_INC, REG_RAX, '0, '0));
        send_item(make_item(OP_DEC, REG_RBX, '0, '0));
        send_item(make_item(OP_INC, REG_RBX, '0, '0));
        send_item(make_item(OP_MOV_IMM, REG_RCX, '0, IMM_MAX));
        send_item(make_item(OP_INC, REG_RCX, '0, '0));
        send_item(make_item(OP_DEC, REG_RCX, '0, '0));
        send_item(make_item(OP_MOV_IMM, REG_RDX, '0, IMM_MIN));
        send_item(make_item(OP_DEC, REG_RDX, '0, '0));
        send_item(make_item(OP_MOV_IMM, REG_RAX, '0, IMM_ONES));
        send_item(make_item(OP_MOV_IMM, REG_RBX, '0, '0));
        send_item(make_item(OP_SUB, REG_RBX, REG_RAX, '0));
        send_item(make_item(OP_MOV_IMM, REG_RDX, '0, IMM_MIN));
        send_item(make_item(OP_SUB, REG_RDX, REG_RBX, '0));
        send_item(make_item(OP_SUB, REG_RCX, REG_RCX, '0));
        // move elimination, including a move onto itself
        send_item(make_item(OP_MOV_REG, REG_RAX, REG_RDX, '0));
        send_item(make_item(OP_MOV_REG, REG_RBX, REG_RBX, '0));
        send_item(make_item(OP_INC, REG_RAX, '0, '0));
        // unused opcodes leave the table alone
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            send_item(make_item(OP_W'(c), REG_IDX_W'($urandom), REG_IDX_W'($urandom), '0));
        send_item(make_item(OP_MOV_IMM, REG_RCX, '0, IMM_0101));
        send_item(make_item(OP_MOV_IMM, REG_RDX, '0, IMM_1010));

        // random traffic until the store is exhausted and well past it
        while (n_sent < ITEMS || n_alloc < ALLOC_SLOTS + TAIL_ALLOCS) begin
            if (n_sent == PAUSE_AT) wait_drained();
            send_item(random_item());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
